// File: hdl/cdfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdfp_pkg;

    // Field and value geometry.
    localparam int VALUE_W     = 48;
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_W      = FRAC_BITS + 4;
    localparam int FRAC_SUM_W  = FRAC_W + 1;
    localparam int WHOLE_W     = VALUE_W - FRAC_BITS;
    localparam int MAG_W       = VALUE_W + 1;
    localparam int FIELD_CHARS = 10;
    localparam int CC_W        = 4;
    localparam int MAX_FIELDS  = 8;
    localparam int FIELD_W     = 3;
    localparam int FPR_W       = 4;
    localparam int MAX_RECORDS = 1024;
    localparam int REC_W       = $clog2(MAX_RECORDS);
    localparam int FRAC_DIGITS_MAX = 14;
    localparam int FD_W        = 4;
    localparam int WEIGHT_W    = 17;
    localparam int BYTE_W      = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_FIELDS_PER_RECORD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTEGER_FIELD_MASK = CFG_IDX_W'(1);
    localparam logic [FPR_W-1:0] FPR_RESET = FPR_W'(2);
    localparam logic [MAX_FIELDS-1:0] INT_MASK_RESET = '0;

    // Saturation limits.
    localparam logic [WHOLE_W-1:0] WHOLE_CAP = WHOLE_W'(1) << (WHOLE_W - 1);
    localparam logic [MAG_W-1:0] POS_MAX = (MAG_W'(1) << (VALUE_W - 1)) - MAG_W'(1);
    localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(1) << (VALUE_W - 1);

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

    typedef enum logic [1:0] {
        MODE_SCAN     = 2'd0,
        MODE_DROP_ONE = 2'd1,
        MODE_COMMENT  = 2'd2,
        MODE_DONE     = 2'd3
    } t_scan_mode;

    // Weight of fraction digit n: 10^-n in unsigned Q0.20, rounded to nearest.
    // Digits from the seventh on carry no weight at this precision.
    function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [FD_W-1:0] n);
        logic [WEIGHT_W-1:0] w;
        unique case (n)
            4'd1:    w = 17'd104858;
            4'd2:    w = 17'd10486;
            4'd3:    w = 17'd1049;
            4'd4:    w = 17'd105;
            4'd5:    w = 17'd10;
            4'd6:    w = 17'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hdl/cdfp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte stream into the parser.
interface cdfp_in_if import cdfp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   in_byte;
    logic                new_file;

    modport source (output valid, output in_byte, output new_file, input ready);
    modport sink   (input valid, input in_byte, input new_file, output ready);
endinterface

// Parsed field values out of the parser.
interface cdfp_out_if import cdfp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  field_value;
    logic [FIELD_W-1:0]         field_number;
    logic [REC_W-1:0]           record_number;
    logic                       record_done;
    logic                       data_done;
    logic                       field_overflow;

    modport source (output valid, output field_value, output field_number,
                    output record_number, output record_done, output data_done,
                    output field_overflow, input ready);
    modport sink   (input valid, input field_value, input field_number,
                    input record_number, input record_done, input data_done,
                    input field_overflow, output ready);
endinterface

// Register write channel.
interface cdfp_cfg_if import cdfp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// File: hdl/csv_decimal_field_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// CSV decimal field parser.
// The byte channel takes one ASCII character per transfer, with new_file set on
// the first byte of a file to restart record and field counting. Each completed
// field leaves on the field channel as a signed Q.16 value with its field and
// record position, end-of-record and end-of-data flags and an overflow flag.
// The register channel is always ready; index 0 sets fields per record and
// index 1 the integer field mask. Write it only while the parser is idle.
// Throughput is one byte per cycle while the receiver takes results. A byte
// is held in an input register, and a single combinational pass (a multiply
// by ten on the whole part, a table-weighted digit add, and the 48-bit
// combine and saturation) updates the parser state and loads the result
// register when that register is free; field values are presented from it.
// When the receiver stalls, the result register holds, the input register
// fills, and the byte channel deasserts ready until the result is taken.
// Reset clears all parser state, empties both registers and restores the
// registers to two fields per record and no integer fields.
module csv_decimal_field_parser_core
    import cdfp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    cdfp_in_if.sink      i_byte_if,
    cdfp_cfg_if.sink     i_cfg_if,
    cdfp_out_if.source   o_field_if
);

    // Configuration registers.
    logic [FPR_W-1:0]      r_fields_per_record;
    logic [MAX_FIELDS-1:0] r_int_mask;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_new_file;

    // Parser state.
    t_scan_mode             r_mode, n_mode;
    logic [FIELD_W-1:0]     r_field, n_field;
    logic [REC_W-1:0]       r_record, n_record;
    logic [CC_W-1:0]        r_char_count, n_char_count;
    logic                   r_neg, n_neg;
    logic                   r_dot, n_dot;
    logic [WHOLE_W-1:0]     r_whole, n_whole;
    logic [FRAC_SUM_W-1:0]  r_frac, n_frac;
    logic [FD_W-1:0]        r_frac_digits, n_frac_digits;
    logic                   r_ovf, n_ovf;

    // Result register.
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out_value;
    logic [FIELD_W-1:0]         r_out_field;
    logic [REC_W-1:0]           r_out_record;
    logic                       r_out_rec_done;
    logic                       r_out_data_done;
    logic                       r_out_ovf;

    // Per-step signals.
    logic                       advance;
    logic                       step;
    t_scan_mode                 eff_mode;
    logic [FIELD_W-1:0]         eff_field;
    logic [REC_W-1:0]           eff_record;
    logic [CC_W-1:0]            eff_char_count;
    logic                       eff_neg;
    logic                       eff_dot;
    logic [WHOLE_W-1:0]         eff_whole;
    logic [FRAC_SUM_W-1:0]      eff_frac;
    logic [FD_W-1:0]            eff_frac_digits;
    logic                       eff_ovf;
    logic [FPR_W-1:0]           fpr_eff;
    logic                       last_field;
    logic                       is_int;
    logic                       is_digit;
    logic [3:0]                 digit;
    logic                       comma_term;
    logic                       line_term;
    logic                       emit;
    logic [WHOLE_W+3:0]         whole_x10;
    logic                       whole_sat;
    logic [WHOLE_W-1:0]         whole_push;
    logic [FD_W-1:0]            frac_index;
    logic [FRAC_SUM_W-1:0]      frac_add;
    logic [FRAC_SUM_W:0]        frac_round;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W-1:0]           mag_sat;
    logic                       neg_out;
    logic                       sat_ovf;
    logic [VALUE_W-1:0]         value_out;

    // Handshakes: a byte moves into the processing pass when the result
    // register is empty or is being taken in this cycle.
    assign advance          = !r_out_valid || o_field_if.ready;
    assign step             = r_in_valid && advance;
    assign i_byte_if.ready  = !r_in_valid || advance;
    assign i_cfg_if.ready   = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fields_per_record <= FPR_RESET;
            r_int_mask          <= INT_MASK_RESET;
        end else if (i_cfg_if.valid) begin
            if (i_cfg_if.reg_index == REG_FIELDS_PER_RECORD) begin
                r_fields_per_record <= i_cfg_if.reg_data[FPR_W-1:0];
            end else if (i_cfg_if.reg_index == REG_INTEGER_FIELD_MASK) begin
                r_int_mask <= i_cfg_if.reg_data[MAX_FIELDS-1:0];
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_if.valid && i_byte_if.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_if.valid && i_byte_if.ready) begin
            r_in_byte     <= i_byte_if.in_byte;
            r_in_new_file <= i_byte_if.new_file;
        end
    end

    // A new file clears the parser state before its first byte is handled.
    always_comb begin
        if (r_in_new_file) begin
            eff_mode        = MODE_SCAN;
            eff_field       = '0;
            eff_record      = '0;
            eff_char_count  = '0;
            eff_neg         = 1'b0;
            eff_dot         = 1'b0;
            eff_whole       = '0;
            eff_frac        = '0;
            eff_frac_digits = '0;
            eff_ovf         = 1'b0;
        end else begin
            eff_mode        = r_mode;
            eff_field       = r_field;
            eff_record      = r_record;
            eff_char_count  = r_char_count;
            eff_neg         = r_neg;
            eff_dot         = r_dot;
            eff_whole       = r_whole;
            eff_frac        = r_frac;
            eff_frac_digits = r_frac_digits;
            eff_ovf         = r_ovf;
        end
    end

    // Field position and terminator classification.
    always_comb begin
        if (r_fields_per_record == '0) begin
            fpr_eff = FPR_W'(1);
        end else if (r_fields_per_record > FPR_W'(MAX_FIELDS)) begin
            fpr_eff = FPR_W'(MAX_FIELDS);
        end else begin
            fpr_eff = r_fields_per_record;
        end
    end

    assign last_field = ({1'b0, eff_field} + FPR_W'(1)) >= fpr_eff;
    assign is_int     = r_int_mask[eff_field];
    assign is_digit   = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign digit      = is_digit ? 4'(r_in_byte - CH_ZERO) : 4'd0;
    assign comma_term = !last_field && (r_in_byte == CH_COMMA);
    assign line_term  = last_field && ((r_in_byte == CH_CR) || (r_in_byte == CH_SEMI) ||
                                       (r_in_byte == CH_SLASH));
    assign emit       = (eff_mode == MODE_SCAN) && (comma_term || line_term);

    // Whole part: shift in one decimal digit, saturating at the cap.
    assign whole_x10  = {eff_whole, 3'b000} + {2'b00, eff_whole, 1'b0} + (WHOLE_W+4)'(digit);
    assign whole_sat  = whole_x10 > (WHOLE_W+4)'(WHOLE_CAP);
    assign whole_push = whole_sat ? WHOLE_CAP : whole_x10[WHOLE_W-1:0];

    // Fraction part: add the digit times its place weight.
    assign frac_index = eff_frac_digits + FD_W'(1);
    assign frac_add   = eff_frac + FRAC_SUM_W'(digit * frac_weight(frac_index));

    // Scan mode sequencing.
    always_comb begin
        n_mode = eff_mode;
        unique case (eff_mode)
            MODE_SCAN: begin
                if (line_term) begin
                    if (r_in_byte == CH_SEMI) begin
                        n_mode = MODE_DONE;
                    end else if (r_in_byte == CH_SLASH) begin
                        n_mode = MODE_COMMENT;
                    end else begin
                        n_mode = MODE_DROP_ONE;
                    end
                end
            end
            MODE_DROP_ONE: begin
                n_mode = MODE_SCAN;
            end
            MODE_COMMENT: begin
                if (r_in_byte == CH_LF) begin
                    n_mode = MODE_SCAN;
                end
            end
            MODE_DONE: begin
                n_mode = MODE_DONE;
            end
        endcase
    end

    // Field accumulation and position counters.
    always_comb begin
        n_field       = eff_field;
        n_record      = eff_record;
        n_char_count  = eff_char_count;
        n_neg         = eff_neg;
        n_dot         = eff_dot;
        n_whole       = eff_whole;
        n_frac        = eff_frac;
        n_frac_digits = eff_frac_digits;
        n_ovf         = eff_ovf;
        if (eff_mode == MODE_SCAN) begin
            if (comma_term || line_term) begin
                n_field       = comma_term ? eff_field + FIELD_W'(1) : '0;
                n_record      = line_term ? eff_record + REC_W'(1) : eff_record;
                n_char_count  = '0;
                n_neg         = 1'b0;
                n_dot         = 1'b0;
                n_whole       = '0;
                n_frac        = '0;
                n_frac_digits = '0;
                n_ovf         = 1'b0;
            end else if (eff_char_count >= CC_W'(FIELD_CHARS)) begin
                // Field is full: the character is dropped.
                n_ovf = 1'b1;
            end else begin
                n_char_count = eff_char_count + CC_W'(1);
                if (is_int) begin
                    n_whole = whole_push;
                    n_ovf   = eff_ovf || whole_sat;
                end else if ((eff_char_count == '0) && (r_in_byte == CH_MINUS)) begin
                    n_neg = 1'b1;
                end else if (!eff_dot) begin
                    if (r_in_byte == CH_DOT) begin
                        n_dot = 1'b1;
                    end else begin
                        n_whole = whole_push;
                        n_ovf   = eff_ovf || whole_sat;
                    end
                end else if (is_digit && (eff_frac_digits < FD_W'(FRAC_DIGITS_MAX))) begin
                    n_frac_digits = frac_index;
                    n_frac        = frac_add;
                end
            end
        end
    end

    // Result value: combine, saturate and apply the sign.
    assign frac_round = is_int ? '0 : ({1'b0, eff_frac} + (FRAC_SUM_W+1)'(8));
    assign mag        = {1'b0, eff_whole, {FRAC_BITS{1'b0}}} + MAG_W'(frac_round >> 4);
    assign neg_out    = eff_neg && !is_int;

    always_comb begin
        if (neg_out) begin
            sat_ovf = mag > NEG_MAX;
            mag_sat = sat_ovf ? NEG_MAX : mag;
            value_out = VALUE_W'(MAG_W'(0) - mag_sat);
        end else begin
            sat_ovf = mag > POS_MAX;
            mag_sat = sat_ovf ? POS_MAX : mag;
            value_out = mag_sat[VALUE_W-1:0];
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_SCAN;
            r_field       <= '0;
            r_record      <= '0;
            r_char_count  <= '0;
            r_neg         <= 1'b0;
            r_dot         <= 1'b0;
            r_whole       <= '0;
            r_frac        <= '0;
            r_frac_digits <= '0;
            r_ovf         <= 1'b0;
        end else if (step) begin
            r_mode        <= n_mode;
            r_field       <= n_field;
            r_record      <= n_record;
            r_char_count  <= n_char_count;
            r_neg         <= n_neg;
            r_dot         <= n_dot;
            r_whole       <= n_whole;
            r_frac        <= n_frac;
            r_frac_digits <= n_frac_digits;
            r_ovf         <= n_ovf;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_value     <= value_out;
            r_out_field     <= eff_field;
            r_out_record    <= eff_record;
            r_out_rec_done  <= line_term;
            r_out_data_done <= line_term && (r_in_byte == CH_SEMI);
            r_out_ovf       <= eff_ovf || sat_ovf;
        end
    end

    assign o_field_if.valid          = r_out_valid;
    assign o_field_if.field_value    = r_out_value;
    assign o_field_if.field_number   = r_out_field;
    assign o_field_if.record_number  = r_out_record;
    assign o_field_if.record_done    = r_out_rec_done;
    assign o_field_if.data_done      = r_out_data_done;
    assign o_field_if.field_overflow = r_out_ovf;

    // End of data always closes a record.
    a_done_ends_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data_done |-> r_out_rec_done)
        else $error("end of data flagged on a field that does not end its record");

    // After end of data nothing is emitted until a new file starts.
    a_quiet_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in_new_file && (r_mode == MODE_DONE) |-> !emit)
        else $error("field emitted after end of data");

    // The character count never passes the field capacity.
    a_char_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_count <= CC_W'(FIELD_CHARS))
        else $error("character count beyond field capacity");

    // A full input register behind a stalled result blocks new bytes.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_field_if.ready |-> !i_byte_if.ready)
        else $error("byte accepted while the pipeline is stalled");

endmodule

`default_nettype wire
